// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the window min/max RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swmm_pkg.sv =====
// ----------------------------------------------------------------------------
// swmm_pkg
// Sizes and controller/datapath handshake types for the window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int WIN_W      = 11;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int POS_W      = ADDR_W + 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int ENTRY_W    = POS_W + SAMPLE_W;

    typedef struct packed {
        logic load;
        logic rd_tail;
        logic head_chk;
        logic tail_chk;
        logic push;
    } swmm_cmd_t;

    typedef struct packed {
        logic head_done;
        logic tail_done;
        logic emit;
        logic out_free;
    } swmm_stat_t;

endpackage

// ===== rtl/swmm_ifs.sv =====
// ----------------------------------------------------------------------------
// swmm_ifs
// Valid/ready channels for samples in and min/max results out.
// ----------------------------------------------------------------------------
interface swmm_sample_if import swmm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swmm_result_if import swmm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [SAMPLE_W-1:0] window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink (input valid, input window_min, input window_max, output ready);
endinterface

// ===== rtl/swmm_ram.sv =====
// ----------------------------------------------------------------------------
// swmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swmm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swmm_deque.sv =====
// ----------------------------------------------------------------------------
// swmm_deque
// One monotonic deque (min or max) in a circular RAM with head and count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swmm_deque import swmm_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       is_max,
    input  swmm_cmd_t                  cmd,
    input  logic                       restart,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [POS_W-1:0]           pos,
    input  logic [WIN_W-1:0]           k,
    output logic                       head_ok,
    output logic                       tail_ok,
    output logic signed [SAMPLE_W-1:0] extreme
);

    logic [ADDR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       hdone_reg, hdone_next;
    logic                       tdone_reg, tdone_next;
    logic signed [SAMPLE_W-1:0] headv_reg;

    logic [ENTRY_W-1:0]         rdata;
    logic signed [SAMPLE_W-1:0] rd_val;
    logic [POS_W-1:0]           rd_pos;
    logic [POS_W-1:0]           age;
    logic                       empty;
    logic                       dominated;
    logic [ADDR_W-1:0]          tail_addr;
    logic [ADDR_W-1:0]          push_addr;
    logic [ADDR_W-1:0]          raddr;

    assign rd_val    = $signed(rdata[SAMPLE_W-1:0]);
    assign rd_pos    = rdata[SAMPLE_W +: POS_W];
    assign age       = pos - rd_pos;  // wraps modulo the position range
    assign empty     = (count_reg == '0);
    assign dominated = is_max ? (rd_val < sample) : (rd_val > sample);
    assign push_addr = head_reg + count_reg[ADDR_W-1:0];
    assign tail_addr = push_addr - ADDR_W'(1);
    assign raddr     = cmd.rd_tail ? tail_addr : head_reg;

    assign head_ok = hdone_reg || empty || (age < POS_W'(k));
    assign tail_ok = tdone_reg || empty || !dominated;
    // an empty deque before the push makes the new sample its head
    assign extreme = empty ? sample : headv_reg;

    swmm_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (push_addr),
        .wdata ({pos, sample}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        hdone_next = hdone_reg;
        tdone_next = tdone_reg;
        if (cmd.load)
        begin
            hdone_next = 1'b0;
            tdone_next = 1'b0;
            if (restart)
            begin
                head_next  = '0;
                count_next = '0;
            end
        end
        else if (cmd.head_chk && !hdone_reg)
        begin
            if (head_ok)
            begin
                hdone_next = 1'b1;
            end
            else
            begin
                head_next  = head_reg + ADDR_W'(1);
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (cmd.tail_chk && !tdone_reg)
        begin
            if (tail_ok)
            begin
                tdone_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            hdone_reg <= 1'b0;
            tdone_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            hdone_reg <= hdone_next;
            tdone_reg <= tdone_next;
        end
    end

    // head entry survives the tail phase unless the deque empties
    always_ff @(posedge clk)
    begin
        if (cmd.head_chk && !hdone_reg && head_ok)
        begin
            headv_reg <= rd_val;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_WINDOW), "deque overfull")
    `ASSERT_ALWAYS(a_one_phase, clk, rst_n, !(cmd.head_chk && cmd.tail_chk), "head and tail check overlap")
    `ASSERT_NEXT(a_push_fills, clk, rst_n, cmd.push, count_reg != '0, "deque empty after push")

endmodule

// ===== rtl/swmm_datapath.sv =====
// ----------------------------------------------------------------------------
// swmm_datapath
// Window register, sample/position counters, both deques and result register.
// ----------------------------------------------------------------------------
module swmm_datapath import swmm_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [WIN_W-1:0]           cfg_wdata,
    input  swmm_cmd_t                  cmd,
    output swmm_stat_t                 stat,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_min,
    output logic signed [SAMPLE_W-1:0] out_max
);

    logic [WIN_W-1:0]           window_size_reg;
    logic [WIN_W-1:0]           k;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           nxt_pos_reg;
    logic [POS_W-1:0]           pos_base;
    logic [CNT_W-1:0]           seen_reg;
    logic [CNT_W-1:0]           seen_base;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_min_reg;
    logic signed [SAMPLE_W-1:0] out_max_reg;
    logic                       min_head_ok, max_head_ok;
    logic                       min_tail_ok, max_tail_ok;
    logic signed [SAMPLE_W-1:0] min_extreme, max_extreme;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = WIN_W'(1);
        end
        else if (window_size_reg > WIN_W'(MAX_WINDOW))
        begin
            k = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            k = window_size_reg;
        end
    end

    assign pos_base  = in_restart ? '0 : nxt_pos_reg;
    assign seen_base = in_restart ? '0 : seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_W'(1);
            pos_reg         <= '0;
            nxt_pos_reg     <= '0;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                pos_reg     <= pos_base;
                nxt_pos_reg <= pos_base + POS_W'(1);
                if (seen_base < CNT_W'(MAX_WINDOW))
                begin
                    seen_reg <= seen_base + CNT_W'(1);
                end
                else
                begin
                    seen_reg <= seen_base;
                end
            end
            if (cmd.push && stat.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= in_sample;
        end
        if (cmd.push && stat.emit)
        begin
            out_min_reg <= min_extreme;
            out_max_reg <= max_extreme;
        end
    end

    swmm_deque u_min (
        .clk     (clk),
        .rst_n   (rst_n),
        .is_max  (1'b0),
        .cmd     (cmd),
        .restart (in_restart),
        .sample  (sample_reg),
        .pos     (pos_reg),
        .k       (k),
        .head_ok (min_head_ok),
        .tail_ok (min_tail_ok),
        .extreme (min_extreme)
    );

    swmm_deque u_max (
        .clk     (clk),
        .rst_n   (rst_n),
        .is_max  (1'b1),
        .cmd     (cmd),
        .restart (in_restart),
        .sample  (sample_reg),
        .pos     (pos_reg),
        .k       (k),
        .head_ok (max_head_ok),
        .tail_ok (max_tail_ok),
        .extreme (max_extreme)
    );

    assign stat.head_done = min_head_ok && max_head_ok;
    assign stat.tail_done = min_tail_ok && max_tail_ok;
    assign stat.emit      = (seen_reg >= CNT_W'(k));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;

endmodule

// ===== rtl/swmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmm_ctrl
// Sequencer: head expiry loop, tail domination loop, then push and result.
// ----------------------------------------------------------------------------
module swmm_ctrl import swmm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  swmm_stat_t stat,
    output swmm_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HEAD_RD  = 3'd1;
    localparam logic [2:0] S_HEAD_CHK = 3'd2;
    localparam logic [2:0] S_TAIL_RD  = 3'd3;
    localparam logic [2:0] S_TAIL_CHK = 3'd4;
    localparam logic [2:0] S_PUSH     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       push_go;

    assign in_ready = (state_reg == S_IDLE);
    // hold the push while a result is due and the output slot is taken
    assign push_go  = (state_reg == S_PUSH) && (!stat.emit || stat.out_free);

    assign cmd.load     = in_valid && in_ready;
    assign cmd.rd_tail  = (state_reg == S_TAIL_RD);
    assign cmd.head_chk = (state_reg == S_HEAD_CHK);
    assign cmd.tail_chk = (state_reg == S_TAIL_CHK);
    assign cmd.push     = push_go;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                // head address is already on the RAM read port in this cycle
                if (in_valid)
                begin
                    state_next = S_HEAD_CHK;
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_CHK;
            end
            S_HEAD_CHK:
            begin
                state_next = stat.head_done ? S_TAIL_RD : S_HEAD_RD;
            end
            S_TAIL_RD:
            begin
                state_next = S_TAIL_CHK;
            end
            S_TAIL_CHK:
            begin
                state_next = stat.tail_done ? S_PUSH : S_TAIL_RD;
            end
            S_PUSH:
            begin
                if (push_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sliding_window_min_max_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_min_max_top
// Running minimum and maximum over the last window_size signed samples.
// ----------------------------------------------------------------------------
// Each sample goes through a min deque and a max deque, each kept in a
// single-port-read circular RAM of 1024 entries, updated in lockstep by one
// sequencer. A sample passes the idle, head check, tail read, tail check and
// push states; every extra head expiry or tail removal step (busier deque)
// adds a RAM read state and a compare state. A sample is accepted only once
// the previous one is pushed. A result is produced once the window has filled
// and waits in an output register, so the next sample is taken while it is
// still pending. The user must write window_size through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. 0 acts as 1
// and values above 1024 act as 1024; restart empties both deques first.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top import swmm_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    cfg_wdata,
    swmm_sample_if.sink         samples,
    swmm_result_if.source       results
);

    swmm_cmd_t  cmd;
    swmm_stat_t stat;

    swmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swmm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .in_sample  (samples.sample),
        .in_restart (samples.restart),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_min    (results.window_min),
        .out_max    (results.window_max)
    );

endmodule
